// File: hdl/rv32i_instruction_executor_assert.svh
// Assertion macros for the instruction executor.
`ifndef RV32I_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RV32I_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Implication checked every clock outside reset.
`define RVX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define RVX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32I instruction executor.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int unsigned MEM_BYTES = 8192;
   localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
   localparam int unsigned MEM_ROWS  = MEM_BYTES / 4;   // rows per byte bank
   localparam int unsigned ROW_AW    = MEM_AW - 2;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
   localparam logic [31:0] SYS_EXIT   = 32'd10;
   localparam logic [31:0] SYS_PRINT_INT = 32'd1;
   localparam logic [31:0] SYS_PRINT_STR = 32'd4;

   typedef enum logic [3:0] {
      CLS_BAD, CLS_ALU, CLS_LOAD, CLS_STORE, CLS_BRANCH, CLS_JALR,
      CLS_JAL, CLS_LUI, CLS_AUIPC, CLS_ECALL
   } cls_type;

   // decoded instruction passed from front to back
   typedef struct packed {
      cls_type     cls;
      logic [2:0]  f3;
      logic        alt;      // sub / sra
      logic        use_imm;  // ALU operand b is immediate
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
   } dec_type;

endpackage

// File: hdl/rvx_decode.sv
// ----------------------------------------------------------------------------
// rvx_decode
// Front end: accepts instruction beats, classifies them, queues decoded ops.
// ----------------------------------------------------------------------------
module rvx_decode import rvx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        dq_valid,
   input  logic        dq_pop,
   output dec_type     dq_data
);

   dec_type dec;
   dec_type q_ff [QUEUE_DEPTH];
   logic    rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic    push;

   always_comb begin
      logic [31:0] w;
      logic [6:0]  f7;
      w = req_instr_word;
      f7 = w[31:25];
      dec.cls = CLS_BAD;
      dec.f3  = w[14:12];
      dec.alt = 1'b0;
      dec.use_imm = 1'b0;
      dec.rd  = w[11:7];
      dec.rs1 = w[19:15];
      dec.rs2 = w[24:20];
      dec.imm = {{20{w[31]}}, w[31:20]};
      unique case (w[6:0])
         OPC_OP: begin
            if (f7 == 7'h00 || (f7 == 7'h20 && (w[14:12] == 3'd0 || w[14:12] == 3'd5)))
               dec.cls = CLS_ALU;
            dec.alt = f7[5];
         end
         OPC_OP_IMM: begin
            dec.use_imm = 1'b1;
            if (w[14:12] == 3'd1) begin
               if (f7 == 7'h00) dec.cls = CLS_ALU;
               dec.imm = {27'd0, w[24:20]};
            end else if (w[14:12] == 3'd5) begin
               if (f7 == 7'h00 || f7 == 7'h20) dec.cls = CLS_ALU;
               dec.alt = f7[5];
               dec.imm = {27'd0, w[24:20]};
            end else begin
               dec.cls = CLS_ALU;
            end
         end
         OPC_LOAD: begin
            if (w[14:12] != 3'd3 && w[14:12] != 3'd6 && w[14:12] != 3'd7)
               dec.cls = CLS_LOAD;
         end
         OPC_STORE: begin
            if (w[14:12] <= 3'd2) dec.cls = CLS_STORE;
            dec.imm = {{20{w[31]}}, w[31:25], w[11:7]};
         end
         OPC_BRANCH: begin
            if (w[14:12] != 3'd2 && w[14:12] != 3'd3) dec.cls = CLS_BRANCH;
            dec.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
         end
         OPC_JALR: if (w[14:12] == 3'd0) dec.cls = CLS_JALR;
         OPC_JAL: begin
            dec.cls = CLS_JAL;
            dec.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
         end
         OPC_LUI: begin
            dec.cls = CLS_LUI;
            dec.imm = {w[31:12], 12'd0};
         end
         OPC_AUIPC: begin
            dec.cls = CLS_AUIPC;
            dec.imm = {w[31:12], 12'd0};
         end
         OPC_SYSTEM: if (w == ECALL_WORD) dec.cls = CLS_ECALL;
         default: dec.cls = CLS_BAD;
      endcase
   end

   assign req_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign dq_valid  = (cnt_ff != 2'd0);
   assign dq_data   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ dq_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(dq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= dec;
   end

endmodule

// File: hdl/rvx_execute.sv
// ----------------------------------------------------------------------------
// rvx_execute
// Back end: register file, PC, data memory; one instruction at a time.
// ----------------------------------------------------------------------------
module rvx_execute import rvx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        dq_valid,
   output logic        dq_pop,
   input  dec_type     dq_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_halted,
   output logic        rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic        rsp_unknown_instr
);

   // stage 0: operands read, address formed; stage 1: memory data, writeback
   logic [31:0] regs_ff [32];
   logic [7:0]  mem0_ff [MEM_ROWS];
   logic [7:0]  mem1_ff [MEM_ROWS];
   logic [7:0]  mem2_ff [MEM_ROWS];
   logic [7:0]  mem3_ff [MEM_ROWS];
   logic [31:0] pc_ff;

   logic        busy_ff;
   dec_type     op_ff;
   logic [31:0] a_ff, b_ff, addr_ff, pc_op_ff;
   logic [7:0]  rb_ff [4];

   logic        out_v_ff;
   logic [31:0] o_npc_ff, o_val_ff, o_prn_ff;
   logic        o_wr_ff, o_halt_ff, o_prn_v_ff, o_bad_ff;
   logic [4:0]  o_rd_ff;

   logic        fire, done;
   logic [31:0] a, b, addr;
   logic [ROW_AW-1:0] row [4];
   logic [1:0]  lane [4];
   logic [7:0]  wdat [4];
   logic        we [4];

   assign a = (dq_data.rs1 == 5'd0) ? 32'd0 : regs_ff[dq_data.rs1];
   assign b = (dq_data.rs2 == 5'd0) ? 32'd0 : regs_ff[dq_data.rs2];
   assign addr = a + dq_data.imm;

   // bank k holds addresses with addr mod 4 == k; lane is the byte position
   // of the access that falls in bank k, row steps up past the start bank
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lane[k] = 2'(k) - addr[1:0];
         row[k]  = addr[MEM_AW-1:2] + ROW_AW'(2'(k) < addr[1:0]);
         wdat[k] = b[{lane[k], 3'b000} +: 8];
         we[k]   = (dq_data.cls == CLS_STORE) &&
                   ({1'b0, lane[k]} < (3'd1 << dq_data.f3[1:0]));
      end
   end

   // one op in the back end at a time: operands are read after writeback
   assign done   = busy_ff && (!out_v_ff || rsp_ready);
   assign fire   = dq_valid && !busy_ff;
   assign dq_pop = fire;

   always_ff @(posedge clock) begin
      if (fire) begin
         rb_ff[0] <= mem0_ff[row[0]];
         rb_ff[1] <= mem1_ff[row[1]];
         rb_ff[2] <= mem2_ff[row[2]];
         rb_ff[3] <= mem3_ff[row[3]];
         if (we[0]) mem0_ff[row[0]] <= wdat[0];
         if (we[1]) mem1_ff[row[1]] <= wdat[1];
         if (we[2]) mem2_ff[row[2]] <= wdat[2];
         if (we[3]) mem3_ff[row[3]] <= wdat[3];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         op_ff    <= dq_data;
         a_ff     <= a;
         b_ff     <= b;
         addr_ff  <= addr;
         pc_op_ff <= pc_ff;
      end
   end

   // stage 1 compute
   logic [31:0] opb, alu, ld, val, npc, bytes;
   logic [63:0] bytes2;
   logic        ok, wr, take, halt, prn;
   always_comb begin
      opb = op_ff.use_imm ? op_ff.imm : b_ff;
      unique case (op_ff.f3)
         3'd0: alu = op_ff.alt ? a_ff - opb : a_ff + opb;
         3'd1: alu = a_ff << opb[4:0];
         3'd2: alu = {31'd0, $signed(a_ff) < $signed(opb)};
         3'd3: alu = {31'd0, a_ff < opb};
         3'd4: alu = a_ff ^ opb;
         3'd5: alu = op_ff.alt ? 32'($signed(a_ff) >>> opb[4:0]) : a_ff >> opb[4:0];
         3'd6: alu = a_ff | opb;
         default: alu = a_ff & opb;
      endcase
      bytes  = {rb_ff[3], rb_ff[2], rb_ff[1], rb_ff[0]};
      bytes2 = {bytes, bytes} >> {addr_ff[1:0], 3'b000};
      bytes  = bytes2[31:0];
      unique case (op_ff.f3)
         3'd0: ld = {{24{bytes[7]}}, bytes[7:0]};
         3'd1: ld = {{16{bytes[15]}}, bytes[15:0]};
         3'd4: ld = {24'd0, bytes[7:0]};
         3'd5: ld = {16'd0, bytes[15:0]};
         default: ld = bytes;
      endcase
      unique case (op_ff.f3)
         3'd0: take = a_ff == b_ff;
         3'd1: take = a_ff != b_ff;
         3'd4: take = $signed(a_ff) < $signed(b_ff);
         3'd5: take = !($signed(a_ff) < $signed(b_ff));
         3'd6: take = a_ff < b_ff;
         default: take = a_ff >= b_ff;
      endcase
      ok = 1'b1; wr = 1'b0; halt = 1'b0; prn = 1'b0; val = 32'd0;
      npc = pc_op_ff + 32'd4;
      unique case (op_ff.cls)
         CLS_ALU:    begin wr = 1'b1; val = alu; end
         CLS_LOAD:   begin wr = 1'b1; val = ld; end
         CLS_STORE:  ;
         CLS_BRANCH: if (take) npc = pc_op_ff + op_ff.imm;
         CLS_JALR:   begin
            wr = 1'b1; val = pc_op_ff + 32'd4;
            npc = addr_ff & 32'hFFFF_FFFE;
         end
         CLS_JAL:    begin wr = 1'b1; val = pc_op_ff + 32'd4; npc = pc_op_ff + op_ff.imm; end
         CLS_LUI:    begin wr = 1'b1; val = op_ff.imm; end
         CLS_AUIPC:  begin wr = 1'b1; val = pc_op_ff + op_ff.imm; end
         CLS_ECALL:  begin
            halt = regs_ff[17] == SYS_EXIT;
            prn  = !halt && (regs_ff[17] == SYS_PRINT_INT || regs_ff[17] == SYS_PRINT_STR);
         end
         default:    begin ok = 1'b0; npc = pc_op_ff; end
      endcase
      if (op_ff.rd == 5'd0) wr = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         pc_ff    <= 32'd0;
         for (int i = 0; i < 32; i++) regs_ff[i] <= 32'd0;
      end else begin
         if (fire) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
         if (done) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
         if (done) begin
            pc_ff <= npc;
            if (wr) regs_ff[op_ff.rd] <= val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         o_npc_ff   <= npc;
         o_wr_ff    <= wr;
         o_rd_ff    <= wr ? op_ff.rd : 5'd0;
         o_val_ff   <= wr ? val : 32'd0;
         o_halt_ff  <= halt;
         o_prn_v_ff <= prn;
         o_prn_ff   <= prn ? regs_ff[10] : 32'd0;
         o_bad_ff   <= !ok;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_next_pc       = o_npc_ff;
   assign rsp_reg_written   = o_wr_ff;
   assign rsp_dest_index    = o_rd_ff;
   assign rsp_dest_value    = o_val_ff;
   assign rsp_halted        = o_halt_ff;
   assign rsp_print_valid   = o_prn_v_ff;
   assign rsp_print_value   = $signed(o_prn_ff);
   assign rsp_unknown_instr = o_bad_ff;

endmodule

// File: hdl/rv32i_instruction_executor.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_executor
// RV32I execute engine: decode front end, queue, execute back end.
// ----------------------------------------------------------------------------
// Usage:
//  req channel carries one instruction word per beat, taken as fetched at the
//  current PC. rsp channel returns one beat per instruction: next PC, the
//  register written, ECALL halt/print flags and an unknown-instruction flag.
//  Front end decodes in the accept cycle into a 2-entry queue.
//  Back end: first reads registers and data memory (four byte banks),
//  then resolves ALU/load/branch and writes back into the output register.
//  Back end takes no new instruction until the current one writes back;
//  its register read to writeback loop runs through the synchronous memory read.
//  Reset clears PC, registers and queue; data memory is not initialized.
//  A stalled rsp holds the output beat; the back end holds its current
//  op until the beat is taken, the queue fills and then req_ready drops.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor import rvx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_halted,
   output logic        rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic        rsp_unknown_instr
);

`include "rv32i_instruction_executor_assert.svh"

   logic    dq_valid, dq_pop;
   dec_type dq_data;

   rvx_decode u_decode (
      .clock, .reset, .req_valid, .req_ready, .req_instr_word,
      .dq_valid, .dq_pop, .dq_data
   );

   rvx_execute u_execute (
      .clock, .reset, .dq_valid, .dq_pop, .dq_data,
      .rsp_valid, .rsp_ready, .rsp_next_pc, .rsp_reg_written, .rsp_dest_index,
      .rsp_dest_value, .rsp_halted, .rsp_print_valid, .rsp_print_value,
      .rsp_unknown_instr
   );

   `RVX_ASSERT_IMPL(a_pop_valid, clock, reset, dq_pop, dq_valid,
      "queue popped while empty")
   `RVX_ASSERT_IMPL(a_unknown_quiet, clock, reset, rsp_valid && rsp_unknown_instr,
      !rsp_reg_written && !rsp_halted && !rsp_print_valid, "unknown op had effects")
   `RVX_ASSERT_IMPL(a_x0, clock, reset, rsp_valid && rsp_reg_written,
      rsp_dest_index != 5'd0, "write to x0 reported")

endmodule
